@@ rtl/core/fac_pkg.sv @@
// Shared types, constants and helpers for the frustum box culling block.
package fac_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int PLANES_PER_TEST = 6;

  localparam int NORM_W     = 16;
  localparam int EPS_W      = 16;
  localparam int DIST_SHIFT = 14;
  localparam int PLANE_W    = 4 * NORM_W;
  localparam int CFG_IDX_W  = 3;

  localparam int NUM_PLANE_REGS = 7;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = CFG_IDX_W'(7);
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(2);

  localparam int BOX_W      = 6 * COORD_WIDTH;
  localparam int S_TDATA_W  = 8 * ((BOX_W + 7) / 8);
  localparam int M_TDATA_W  = 8;

  localparam int PROD_W  = NORM_W + COORD_WIDTH;
  localparam int DTERM_W = NORM_W + DIST_SHIFT;
  localparam int SUM_W   = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 2;

  localparam logic OP_VIEW_SET   = 1'b0;
  localparam logic OP_OBJECT_SET = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [NORM_W-1:0] norm_t;

  typedef struct packed {
    norm_t d;
    norm_t nz;
    norm_t ny;
    norm_t nx;
  } plane_t;

  typedef struct packed {
    coord_t max_z;
    coord_t max_y;
    coord_t max_x;
    coord_t min_z;
    coord_t min_y;
    coord_t min_x;
  } box_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
  } stage_ld_t;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE = 2'd0,
    VERDICT_INSIDE  = 2'd1,
    VERDICT_OVERLAP = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    PL_TOP        = 3'd0,
    PL_RIGHT      = 3'd1,
    PL_BOTTOM     = 3'd2,
    PL_LEFT       = 3'd3,
    PL_FAR        = 3'd4,
    PL_NEAR       = 3'd5,
    PL_OBJECT_FAR = 3'd6
  } plane_sel_t;

  // Maps a test slot of the chosen plane set to its plane register.
  function automatic plane_sel_t plane_slot(input logic opcode, input logic [2:0] slot);
    plane_sel_t sel;
    unique case (slot)
      3'd0:    sel = PL_TOP;
      3'd1:    sel = PL_RIGHT;
      3'd2:    sel = PL_BOTTOM;
      3'd3:    sel = PL_LEFT;
      3'd4:    sel = (opcode == OP_OBJECT_SET) ? PL_NEAR : PL_FAR;
      3'd5:    sel = (opcode == OP_OBJECT_SET) ? PL_OBJECT_FAR : PL_NEAR;
      3'd6:    sel = PL_TOP;
      default: sel = PL_RIGHT;
    endcase
    return sel;
  endfunction

endpackage

@@ rtl/core/fac_cfg.sv @@
// Configuration register file holding the frustum planes and epsilon.
module fac_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [fac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fac_pkg::PLANE_W-1:0]    cfg_wdata,
  output fac_pkg::plane_t                planes [fac_pkg::NUM_PLANE_REGS],
  output logic [fac_pkg::EPS_W-1:0]      eps
);
  import fac_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANE_REGS; i++) begin
        planes[i] <= '0;
      end
      eps <= EPS_RESET;
    end else if (cfg_wr_en) begin
      priority if (32'(cfg_index) < NUM_PLANE_REGS) begin
        planes[cfg_index] <= plane_t'(cfg_wdata);
      end else if (cfg_index == REG_EPSILON) begin
        eps <= cfg_wdata[EPS_W-1:0];
      end
    end
  end

endmodule

@@ rtl/core/fac_lane.sv @@
// One plane lane: corner selection and products, then distance sums and threshold tests.
module fac_lane (
  input  logic                       clk,
  input  fac_pkg::stage_ld_t         ld,
  input  fac_pkg::plane_t            plane,
  input  logic [fac_pkg::EPS_W-1:0]  eps,
  input  fac_pkg::box_t              box,
  output logic                       near_hit,
  output logic                       far_hit
);
  import fac_pkg::*;

  coord_t lo [3];
  coord_t hi [3];
  norm_t  n  [3];
  coord_t near_c [3];
  coord_t far_c  [3];

  logic signed [PROD_W-1:0]  near_prod [3];
  logic signed [PROD_W-1:0]  far_prod  [3];
  logic signed [DTERM_W-1:0] dterm;

  logic signed [SUM_W-1:0] near_sum;
  logic signed [SUM_W-1:0] far_sum;
  logic signed [SUM_W-1:0] eps_ext;

  always_comb begin
    lo[0] = box.min_x;
    lo[1] = box.min_y;
    lo[2] = box.min_z;
    hi[0] = box.max_x;
    hi[1] = box.max_y;
    hi[2] = box.max_z;
    n[0]  = plane.nx;
    n[1]  = plane.ny;
    n[2]  = plane.nz;
    for (int a = 0; a < 3; a++) begin
      if ($signed({n[a][NORM_W-1], n[a]}) > $signed({1'b0, eps})) begin
        near_c[a] = lo[a];
        far_c[a]  = hi[a];
      end else begin
        near_c[a] = hi[a];
        far_c[a]  = lo[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      for (int a = 0; a < 3; a++) begin
        near_prod[a] <= n[a] * near_c[a];
        far_prod[a]  <= n[a] * far_c[a];
      end
      dterm <= {plane.d, {DIST_SHIFT{1'b0}}};
    end
  end

  always_comb begin
    eps_ext  = $signed({{(SUM_W - EPS_W){1'b0}}, eps});
    near_sum = SUM_W'(near_prod[0]) + SUM_W'(near_prod[1]) + SUM_W'(near_prod[2])
             + SUM_W'(dterm);
    far_sum  = SUM_W'(far_prod[0]) + SUM_W'(far_prod[1]) + SUM_W'(far_prod[2])
             + SUM_W'(dterm);
  end

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      near_hit <= near_sum > eps_ext;
      far_hit  <= far_sum > eps_ext;
    end
  end

endmodule

@@ rtl/core/frustum_aabb_cull.sv @@
// Top level of the frustum box culling block: stream ports, pipeline control and verdict.
//
// Each word on the input stream is one axis-aligned box and a plane-set selector; each
// word on the output stream is its verdict, in order. When the output is not stalled the
// block takes one box per cycle, and each box passes through the product, hit and
// verdict registers in turn. All planes of a set are tested at once in parallel lanes,
// each with six 16 by 16 bit multipliers for the near and far corners; the multiply,
// the distance sum and the verdict reduction are separate register stages. The user
// must write configuration only while no word is in flight; the block does not enforce it.
module frustum_aabb_cull (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0 up: min_x, min_y, min_z, max_x, max_y, max_z.
  input  logic [fac_pkg::S_TDATA_W-1:0]   s_tdata,
  // Fields from bit 0 up: opcode.
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0 up: verdict, then zero fill.
  output logic [fac_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            cfg_wr_en,
  input  logic [fac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fac_pkg::PLANE_W-1:0]     cfg_wdata
);
  import fac_pkg::*;

  plane_t     planes [NUM_PLANE_REGS];
  logic [EPS_W-1:0] eps;
  box_t       box;
  stage_ld_t  ld;

  logic v1;
  logic v2;
  logic v3;
  logic rdy1;
  logic rdy2;
  logic rdy3;

  logic [PLANES_PER_TEST-1:0] near_hit;
  logic [PLANES_PER_TEST-1:0] far_hit;
  verdict_t verdict;

  fac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .planes    (planes),
    .eps       (eps)
  );

  assign box = box_t'(s_tdata[BOX_W-1:0]);

  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign ld.ld1   = s_tvalid && rdy1;
  assign ld.ld2   = v1 && rdy2;

  for (genvar p = 0; p < PLANES_PER_TEST; p++) begin : g_lane
    fac_lane u_lane (
      .clk      (clk),
      .ld       (ld),
      .plane    (planes[plane_slot(s_tuser, 3'(p))]),
      .eps      (eps),
      .box      (box),
      .near_hit (near_hit[p]),
      .far_hit  (far_hit[p])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= s_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      priority if (|near_hit) begin
        verdict <= VERDICT_OUTSIDE;
      end else if (|far_hit) begin
        verdict <= VERDICT_OVERLAP;
      end else begin
        verdict <= VERDICT_INSIDE;
      end
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {{(M_TDATA_W - 2){1'b0}}, verdict};

endmodule
